FILE: design/lkc_pkg.sv
// shared types and constants for the lru keyed table cache
package lkc_pkg;

  localparam int DEF_CAPACITY  = 16;
  localparam int COUNT_W       = 32;
  localparam int KEY_W         = 2 * COUNT_W;
  localparam int SLOT_W        = 4;
  localparam int MAX_ENTRIES_W = 5;
  localparam int APB_DATA_W    = 32;
  localparam int APB_ADDR_W    = 2;

  localparam logic [MAX_ENTRIES_W-1:0] MAX_ENTRIES_RESET = 5'd16;
  localparam logic [APB_ADDR_W-1:0]    ADDR_MAX_ENTRIES  = 2'd0;

  typedef enum logic [1:0] {
    ST_HIT    = 2'd0,
    ST_MISS   = 2'd1,
    ST_REJECT = 2'd2
  } status_t;

  // broadcast update command to every entry
  typedef struct packed {
    logic hit;
    logic install;
  } cell_cmd_t;

endpackage

FILE: design/lkc_cfg.sv
// apb register block holding the entry limit
module lkc_cfg import lkc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_W-1:0]    paddr,
  input  logic [APB_DATA_W-1:0]    pwdata,
  output logic [APB_DATA_W-1:0]    prdata,
  output logic                     pready,
  output logic [MAX_ENTRIES_W-1:0] max_entries
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == ADDR_MAX_ENTRIES);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= MAX_ENTRIES_RESET;
    end else if (wr_en) begin
      max_entries <= pwdata[MAX_ENTRIES_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_MAX_ENTRIES) begin
      prdata = {{(APB_DATA_W-MAX_ENTRIES_W){1'b0}}, max_entries};
    end
  end

endmodule

FILE: design/lkc_entry.sv
// one directory entry: key store, tag compare and recency rank
module lkc_entry import lkc_pkg::*; #(
  parameter int RANK_W = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  cell_cmd_t         cmd,
  input  logic              hit_sel,
  input  logic              tgt_sel,
  input  logic [RANK_W-1:0] hit_rank,
  input  logic [KEY_W-1:0]  key_in,
  output logic              valid,
  output logic [RANK_W-1:0] rank,
  output logic [KEY_W-1:0]  key,
  output logic              match
);

  assign match = valid && (key == key_in);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rank  <= '0;
    end else if (cmd.install) begin
      if (tgt_sel) begin
        valid <= 1'b1;
        rank  <= '0;
      end else if (valid) begin
        rank <= rank + 1'b1;
      end
    end else if (cmd.hit) begin
      if (hit_sel) begin
        rank <= '0;
      end else if (valid && (rank < hit_rank)) begin
        rank <= rank + 1'b1;
      end
    end
  end

  // key store, no reset
  always_ff @(posedge clk) begin
    if (cmd.install && tgt_sel) begin
      key <= key_in;
    end
  end

endmodule

FILE: design/lru_keyed_table_cache_unit.sv
// top level of the lru keyed table cache directory
// flow: a request is taken into the input register, looked up, and its result registered in
//   the result register, where it is held until taken
// throughput: one request per cycle, set by the parallel tag compare
//   and rank update across all entries; a stalled result holds the request in the input register
// reset (synchronous, active high): all entries invalid, ranks and count zero,
//   max_entries back to 16; stored keys are not cleared
module lru_keyed_table_cache_unit import lkc_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                  clk,
  input  logic                  rst,
  // request channel
  input  logic                  req_valid,
  output logic                  req_stall,
  input  logic [COUNT_W-1:0]    from_count,
  input  logic [COUNT_W-1:0]    to_count,
  // result channel
  output logic                  res_valid,
  input  logic                  res_stall,
  output logic [1:0]            status,
  output logic [SLOT_W-1:0]     slot,
  output logic                  evicted,
  output logic [COUNT_W-1:0]    evicted_from,
  output logic [COUNT_W-1:0]    evicted_to,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  // index, rank and count widths all follow from the capacity
  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int RANK_W = IDX_W;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (CNT_W > MAX_ENTRIES_W) ? CNT_W : MAX_ENTRIES_W;
  localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

  // configuration
  logic [MAX_ENTRIES_W-1:0] max_entries;

  lkc_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .max_entries (max_entries)
  );

  // input register
  logic               s1_valid;
  logic [COUNT_W-1:0] s1_from;
  logic [COUNT_W-1:0] s1_to;
  logic               accept;
  logic               process;
  logic               out_free;

  // result register is free when empty or being drained this cycle
  assign out_free  = !res_valid || !res_stall;
  assign process   = s1_valid && out_free;
  assign req_stall = s1_valid && !out_free;
  assign accept    = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (process) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_from <= from_count;
      s1_to   <= to_count;
    end
  end

  // directory entries
  logic [KEY_W-1:0]  key_in;
  cell_cmd_t         cmd;
  logic [RANK_W-1:0] hit_rank;
  logic [CAPACITY-1:0] hit_sel;
  logic [CAPACITY-1:0] tgt_sel;
  logic [CAPACITY-1:0] ent_valid;
  logic [RANK_W-1:0]   ent_rank [CAPACITY];
  logic [KEY_W-1:0]    ent_key  [CAPACITY];

  assign key_in = {s1_from, s1_to};

  for (genvar g = 0; g < CAPACITY; g++) begin : g_entry
    lkc_entry #(.RANK_W(RANK_W)) u_entry (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .hit_sel  (hit_sel[g]),
      .tgt_sel  (tgt_sel[g]),
      .hit_rank (hit_rank),
      .key_in   (key_in),
      .valid    (ent_valid[g]),
      .rank     (ent_rank[g]),
      .key      (ent_key[g]),
      .match    (hit_sel[g])
    );
  end

  // entry count
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_m1;
  logic [CMP_W-1:0] limit;
  logic [CMP_W-1:0] count_ext;

  assign count_m1  = count - 1'b1;
  assign count_ext = CMP_W'(count);

  // entry limit: zero reads as one, anything above capacity as capacity
  always_comb begin
    limit = CMP_W'(max_entries);
    if (max_entries == '0) begin
      limit = CMP_W'(1);
    end
    if (limit > CAP_C) begin
      limit = CAP_C;
    end
  end

  // lookup and replacement choice
  logic               reject;
  logic               any_hit;
  logic               do_evict;
  logic [CAPACITY-1:0] victim_sel;
  logic [CAPACITY-1:0] free_sel;
  logic [IDX_W-1:0]   hit_idx;
  logic [IDX_W-1:0]   tgt_idx;
  logic [KEY_W-1:0]   victim_key;
  logic               found;

  assign reject   = (s1_from == '0) || (s1_to == '0);
  assign any_hit  = |hit_sel;
  // count never exceeds capacity, so reaching the limit means evict
  assign do_evict = (count_ext >= limit) || (count_ext >= CAP_C);

  always_comb begin
    hit_idx    = '0;
    hit_rank   = '0;
    victim_key = '0;
    free_sel   = '0;
    found      = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      // valid ranks form a permutation, so the least recent has rank count-1
      victim_sel[i] = ent_valid[i] && (CNT_W'(ent_rank[i]) == count_m1);
      if (hit_sel[i]) begin
        hit_idx  = hit_idx | IDX_W'(i);
        hit_rank = hit_rank | ent_rank[i];
      end
      if (victim_sel[i]) begin
        victim_key = victim_key | ent_key[i];
      end
      // lowest free slot
      if (!ent_valid[i] && !found) begin
        free_sel[i] = 1'b1;
        found       = 1'b1;
      end
    end
  end

  assign tgt_sel = do_evict ? victim_sel : free_sel;

  always_comb begin
    tgt_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (tgt_sel[i]) begin
        tgt_idx = tgt_idx | IDX_W'(i);
      end
    end
  end

  assign cmd.hit     = process && !reject && any_hit;
  assign cmd.install = process && !reject && !any_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.install && !do_evict) begin
      count <= count + 1'b1;
    end
  end

  // result register
  status_t              res_status;
  logic [IDX_W+SLOT_W-1:0] hit_slot_ext;
  logic [IDX_W+SLOT_W-1:0] tgt_slot_ext;

  // slot numbers are masked to the field width
  assign hit_slot_ext = {{SLOT_W{1'b0}}, hit_idx};
  assign tgt_slot_ext = {{SLOT_W{1'b0}}, tgt_idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (process) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      priority if (reject) begin
        res_status   <= ST_REJECT;
        slot         <= '0;
        evicted      <= 1'b0;
        evicted_from <= '0;
        evicted_to   <= '0;
      end else if (any_hit) begin
        res_status   <= ST_HIT;
        slot         <= hit_slot_ext[SLOT_W-1:0];
        evicted      <= 1'b0;
        evicted_from <= '0;
        evicted_to   <= '0;
      end else begin
        res_status   <= ST_MISS;
        slot         <= tgt_slot_ext[SLOT_W-1:0];
        evicted      <= do_evict;
        evicted_from <= do_evict ? victim_key[KEY_W-1:COUNT_W] : '0;
        evicted_to   <= do_evict ? victim_key[COUNT_W-1:0] : '0;
      end
    end
  end

  assign status = res_status;

  // checks on directory bookkeeping and request stalls
  a_count_matches_valid : assert property (@(posedge clk) disable iff (rst)
    $countones(ent_valid) == int'(count))
    else $error("entry count differs from number of valid entries");

  a_hit_unique : assert property (@(posedge clk) disable iff (rst)
    $onehot0(hit_sel))
    else $error("key matched in more than one entry");

  a_evict_keeps_count : assert property (@(posedge clk) disable iff (rst)
    cmd.install && do_evict |=> count == $past(count))
    else $error("eviction changed the entry count");

  a_victim_found : assert property (@(posedge clk) disable iff (rst)
    cmd.install |-> $onehot(tgt_sel))
    else $error("no single slot chosen for install");

  a_stall_only_when_held : assert property (@(posedge clk) disable iff (rst)
    req_stall |-> s1_valid && res_valid)
    else $error("request stalled with nothing held");

endmodule
